@@ design/dpbp_pkg.sv @@
// shared constants, codes and types of the depth pixel back-projection unit
package dpbp_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;

  localparam int unsigned DepthW    = 16;
  localparam int unsigned PixW      = 12;
  localparam int unsigned CenterW   = 16;
  localparam int unsigned InvW      = 32;
  localparam int unsigned PointW    = 37;
  localparam int unsigned MagW      = 16;
  localparam int unsigned MzW       = MagW + DepthW;
  localparam int unsigned ProdW     = MzW + InvW;
  localparam int unsigned FracShift = 28;
  localparam int unsigned SubPixW   = 4;

  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned ApbAddrW  = 4;

  typedef enum logic [1:0] {
    RegCenterCol = 2'd0,
    RegCenterRow = 2'd1,
    RegInvFocalX = 2'd2,
    RegInvFocalY = 2'd3
  } dpbp_reg_e;

  // per-stage load enables of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } dpbp_adv_t;

endpackage

@@ design/dpbp_pix_if.sv @@
// valid/ready channel that carries one depth pixel with its column and row
interface dpbp_pix_if;
  import dpbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [DepthW-1:0] depth;
  logic [PixW-1:0]   pixel_col;
  logic [PixW-1:0]   pixel_row;

  modport source (output valid, output depth, output pixel_col, output pixel_row,
                  input ready);
  modport sink   (input valid, input depth, input pixel_col, input pixel_row,
                  output ready);
endinterface

@@ design/dpbp_pt_if.sv @@
// valid/ready channel that carries one 3D point with its source pixel
interface dpbp_pt_if;
  import dpbp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [PointW-1:0] point_x;
  logic signed [PointW-1:0] point_y;
  logic [DepthW-1:0]        point_z;
  logic [PixW-1:0]          source_col;
  logic [PixW-1:0]          source_row;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output source_col, output source_row, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  input source_col, input source_row, output ready);
endinterface

@@ design/dpbp_axis.sv @@
// four-stage projection of one axis: offset, offset*depth, *reciprocal, shift and sign
module dpbp_axis (
  input  logic                               clk_i,
  input  dpbp_pkg::dpbp_adv_t                adv_i,
  input  logic [dpbp_pkg::PixW-1:0]          pix_i,
  input  logic [dpbp_pkg::CenterW-1:0]       center_i,
  input  logic [dpbp_pkg::DepthW-1:0]        depth_i,
  input  logic [dpbp_pkg::InvW-1:0]          inv_i,
  output logic signed [dpbp_pkg::PointW-1:0] coord_o
);
  import dpbp_pkg::*;

  logic [CenterW-1:0] pos;
  logic               neg1_d;
  logic [MagW-1:0]    mag1_d;

  logic               neg1_q, neg2_q, neg3_q;
  logic [MagW-1:0]    mag1_q;
  logic [DepthW-1:0]  z1_q;
  logic [MzW-1:0]     mz2_q;
  logic [ProdW-1:0]   prod3_q;
  logic [PointW-1:0]  q4;
  logic               sticky;
  logic [PointW-1:0]  coord4_d;
  logic [PointW-1:0]  coord4_q;

  assign pos    = {pix_i, SubPixW'(0)};
  assign neg1_d = center_i > pos;
  assign mag1_d = neg1_d ? MagW'(center_i - pos) : MagW'(pos - center_i);

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      neg1_q <= neg1_d;
      mag1_q <= mag1_d;
      z1_q   <= depth_i;
    end
    if (adv_i.s2) begin
      neg2_q <= neg1_q;
      mz2_q  <= MzW'(mag1_q) * MzW'(z1_q);
    end
    if (adv_i.s3) begin
      neg3_q  <= neg2_q;
      prod3_q <= ProdW'(mz2_q) * ProdW'(inv_i);
    end
    if (adv_i.s4) begin
      coord4_q <= coord4_d;
    end
  end

  // negative offsets round the magnitude up so the result floors
  assign sticky   = prod3_q[FracShift-1:0] != '0;
  assign q4       = PointW'(prod3_q[ProdW-1:FracShift])
                  + PointW'(neg3_q & sticky);
  assign coord4_d = neg3_q ? PointW'(PointW'(0) - q4) : q4;

  assign coord_o = signed'(coord4_q);

endmodule

@@ design/depth_pixel_back_projection_unit.sv @@
// Back-projects depth pixels to 3D points through a four-stage pipeline. One pixel
// is taken per clock while the output is not held off; its point passes the stages
// in order, the output register being the last. The sustained rate is one item per
// cycle, set by the two chained multipliers of each axis (offset times depth, then
// times the reciprocal focal length) that each own a stage. A pixel with zero depth
// or outside the frame produces no point. The user must write the registers only
// over the APB port (center_col 0x0, center_row 0x4, inv_focal_x 0x8, inv_focal_y
// 0xC, reset to zero) while no pixel is in flight; the block does not enforce it.
module depth_pixel_back_projection_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [dpbp_pkg::ApbAddrW-1:0]   paddr_i,
  input  logic [dpbp_pkg::ApbDataW-1:0]   pwdata_i,
  output logic [dpbp_pkg::ApbDataW-1:0]   prdata_o,
  output logic                            pready_o,
  dpbp_pix_if.sink                        pix_i,
  dpbp_pt_if.source                       pt_o
);
  import dpbp_pkg::*;

  logic [CenterW-1:0] center_col_q;
  logic [CenterW-1:0] center_row_q;
  logic [InvW-1:0]    inv_focal_x_q;
  logic [InvW-1:0]    inv_focal_y_q;
  dpbp_reg_e          reg_idx;
  logic               cfg_wr;

  dpbp_adv_t          adv;
  logic               v1_q, v2_q, v3_q, v4_q;
  logic               keep;
  logic [DepthW-1:0]  z1_q, z2_q, z3_q, z4_q;
  logic [PixW-1:0]    col1_q, col2_q, col3_q, col4_q;
  logic [PixW-1:0]    row1_q, row2_q, row3_q, row4_q;

  // configuration port
  assign pready_o = 1'b1;
  assign reg_idx  = dpbp_reg_e'(paddr_i[ApbAddrW-1:2]);
  assign cfg_wr   = psel_i & penable_i & pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_col_q  <= '0;
      center_row_q  <= '0;
      inv_focal_x_q <= '0;
      inv_focal_y_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegCenterCol: center_col_q  <= pwdata_i[CenterW-1:0];
        RegCenterRow: center_row_q  <= pwdata_i[CenterW-1:0];
        RegInvFocalX: inv_focal_x_q <= pwdata_i[InvW-1:0];
        RegInvFocalY: inv_focal_y_q <= pwdata_i[InvW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegCenterCol: prdata_o = ApbDataW'(center_col_q);
      RegCenterRow: prdata_o = ApbDataW'(center_row_q);
      RegInvFocalX: prdata_o = ApbDataW'(inv_focal_x_q);
      RegInvFocalY: prdata_o = ApbDataW'(inv_focal_y_q);
      default:      prdata_o = '0;
    endcase
  end

  // a stage loads when it is empty or its content moves on
  assign adv.s4 = !v4_q || pt_o.ready;
  assign adv.s3 = !v3_q || adv.s4;
  assign adv.s2 = !v2_q || adv.s3;
  assign adv.s1 = !v1_q || adv.s2;
  assign pix_i.ready = adv.s1;

  // empty samples and pixels outside the frame are dropped at entry
  assign keep = pix_i.valid && (pix_i.depth != '0)
             && ({1'b0, pix_i.pixel_col} < (PixW+1)'(MaxWidth))
             && ({1'b0, pix_i.pixel_row} < (PixW+1)'(MaxHeight));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv.s1) v1_q <= keep;
      if (adv.s2) v2_q <= v1_q;
      if (adv.s3) v3_q <= v2_q;
      if (adv.s4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv.s1) begin
      z1_q   <= pix_i.depth;
      col1_q <= pix_i.pixel_col;
      row1_q <= pix_i.pixel_row;
    end
    if (adv.s2) begin
      z2_q   <= z1_q;
      col2_q <= col1_q;
      row2_q <= row1_q;
    end
    if (adv.s3) begin
      z3_q   <= z2_q;
      col3_q <= col2_q;
      row3_q <= row2_q;
    end
    if (adv.s4) begin
      z4_q   <= z3_q;
      col4_q <= col3_q;
      row4_q <= row3_q;
    end
  end

  dpbp_axis u_axis_x (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .pix_i    (pix_i.pixel_col),
    .center_i (center_col_q),
    .depth_i  (pix_i.depth),
    .inv_i    (inv_focal_x_q),
    .coord_o  (pt_o.point_x)
  );

  dpbp_axis u_axis_y (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .pix_i    (pix_i.pixel_row),
    .center_i (center_row_q),
    .depth_i  (pix_i.depth),
    .inv_i    (inv_focal_y_q),
    .coord_o  (pt_o.point_y)
  );

  assign pt_o.valid      = v4_q;
  assign pt_o.point_z    = z4_q;
  assign pt_o.source_col = col4_q;
  assign pt_o.source_row = row4_q;

  // an empty pipeline always takes a pixel
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!v1_q && !v2_q && !v3_q && !v4_q) |-> pix_i.ready)
    else $error("pipeline empty but input not ready");

  // a valid in-frame pixel transfer enters the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready && pix_i.depth != '0) |=> v1_q)
    else $error("accepted pixel lost at entry");

  // zero depth never reaches the output
  a_nonzero_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_o.valid |-> (pt_o.point_z != '0))
    else $error("point with zero depth delivered");

endmodule

@@ test/depth_pixel_back_projection_unit_tb.sv @@
// self-checking testbench of the depth pixel back-projection unit
module depth_pixel_back_projection_unit_tb;
  import dpbp_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic signed [PointW-1:0] x;
    logic signed [PointW-1:0] y;
    logic [DepthW-1:0]        z;
    logic [PixW-1:0]          col;
    logic [PixW-1:0]          row;
  } point_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel_i;
  logic                penable_i;
  logic                pwrite_i;
  logic [ApbAddrW-1:0] paddr_i;
  logic [ApbDataW-1:0] pwdata_i;
  logic [ApbDataW-1:0] prdata_o;
  logic                pready_o;

  dpbp_pix_if pix ();
  dpbp_pt_if  pt ();

  depth_pixel_back_projection_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel_i   (psel_i),
    .penable_i(penable_i),
    .pwrite_i (pwrite_i),
    .paddr_i  (paddr_i),
    .pwdata_i (pwdata_i),
    .prdata_o (prdata_o),
    .pready_o (pready_o),
    .pix_i    (pix),
    .pt_o     (pt)
  );

  // shadow copy of the camera registers
  logic [CenterW-1:0] cam_cx;
  logic [CenterW-1:0] cam_cy;
  logic [InvW-1:0]    cam_inv_fx;
  logic [InvW-1:0]    cam_inv_fy;

  point_t points_due[$];
  point_t due_pt;
  int     mismatches;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     stall_cycles;
  int     hold_left;
  bit     hold_req;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // one axis: (pix*16 - center) * z * inv in Q.36, floored to Q.8
  function automatic logic signed [PointW-1:0] point_coord(
    logic [PixW-1:0] pix_idx, logic [CenterW-1:0] center,
    logic [DepthW-1:0] z, logic [InvW-1:0] inv);
    logic [63:0] pos;
    logic [63:0] ctr;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] q;
    logic        below;
    pos = {48'd0, pix_idx, 4'd0};
    ctr = {48'd0, center};
    below = ctr > pos;
    mag = below ? ctr - pos : pos - ctr;
    prod = mag * {48'd0, z} * {32'd0, inv};
    q = prod >> FracShift;
    if (below) begin
      if (prod[FracShift-1:0] != '0) q = q + 64'd1;
      q = 64'd0 - q;
    end
    return q[PointW-1:0];
  endfunction

  function automatic point_t predict_point(
    logic [DepthW-1:0] z, logic [PixW-1:0] col, logic [PixW-1:0] row);
    point_t p;
    p.x = point_coord(col, cam_cx, z, cam_inv_fx);
    p.y = point_coord(row, cam_cy, z, cam_inv_fy);
    p.z = z;
    p.col = col;
    p.row = row;
    return p;
  endfunction

  task automatic write_reg(dpbp_reg_e r, logic [ApbDataW-1:0] val);
    @(negedge clk_i);
    psel_i = 1'b1;
    penable_i = 1'b0;
    pwrite_i = 1'b1;
    paddr_i = {r, 2'b00};
    pwdata_i = val;
    @(negedge clk_i);
    penable_i = 1'b1;
    do @(posedge clk_i); while (!pready_o);
    case (r)
      RegCenterCol: cam_cx = val[CenterW-1:0];
      RegCenterRow: cam_cy = val[CenterW-1:0];
      RegInvFocalX: cam_inv_fx = val[InvW-1:0];
      RegInvFocalY: cam_inv_fy = val[InvW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel_i = 1'b0;
    penable_i = 1'b0;
    pwrite_i = 1'b0;
  endtask

  task automatic send_pixel(logic [DepthW-1:0] z, logic [PixW-1:0] col,
                            logic [PixW-1:0] row);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      pix.valid = 1'b0;
      @(negedge clk_i);
    end
    pix.valid = 1'b1;
    pix.depth = z;
    pix.pixel_col = col;
    pix.pixel_row = row;
    do @(posedge clk_i); while (!pix.ready);
    // zero depth is dropped by the block
    if (z != '0) points_due.insert(points_due.size(), predict_point(z, col, row));
  endtask

  // stop offering, wait for all points, then cover dropped pixels still in flight
  task automatic settle();
    @(negedge clk_i);
    pix.valid = 1'b0;
    while (points_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic configure(logic [CenterW-1:0] cx, logic [CenterW-1:0] cy,
                           logic [InvW-1:0] ifx, logic [InvW-1:0] ify);
    settle();
    write_reg(RegCenterCol, ApbDataW'(cx));
    write_reg(RegCenterRow, ApbDataW'(cy));
    write_reg(RegInvFocalX, ApbDataW'(ifx));
    write_reg(RegInvFocalY, ApbDataW'(ify));
  endtask

  function automatic logic [31:0] pick_value(int unsigned width);
    logic [31:0] top;
    top = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
    case ($urandom_range(5))
      0: return 32'd0;
      1: return top;
      default: return $urandom() & top;
    endcase
  endfunction

  function automatic logic [DepthW-1:0] pick_depth();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return DepthW'(1);
      default: return DepthW'($urandom());
    endcase
  endfunction

  function automatic logic [PixW-1:0] pick_pix();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PixW'($urandom());
    endcase
  endfunction

  // registers still at their reset value: every point lands on the z axis
  task automatic test_reset_state();
    send_pixel(16'd1, 12'd0, 12'd0);
    send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
    send_pixel(16'd0, 12'd5, 12'd9);
    send_pixel(16'd1234, 12'd640, 12'd360);
  endtask

  task automatic test_corners();
    // center far right and top, largest reciprocals: extreme negative x
    configure(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(16'hFFFF, 12'd0, 12'hFFF);
    send_pixel(16'hFFFF, 12'hFFF, 12'd0);
    send_pixel(16'd1, 12'd0, 12'd0);
    send_pixel(16'd0, 12'hFFF, 12'hFFF);
    send_pixel(16'd1, 12'hFFF, 12'hFFF);
    // zero reciprocal and center at origin on x, center row at its maximum: extreme negative y
    configure(16'h0000, 16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
    send_pixel(16'hFFFF, 12'd0, 12'd0);
    send_pixel(16'd0, 12'd0, 12'd0);
    send_pixel(16'd7, 12'd100, 12'd200);
    // mid-frame center with a fractional part, small focal reciprocals
    configure(16'h7FF8, 16'h5A08, 32'h0000_0001, 32'h0034_5678);
    send_pixel(16'd1, 12'd2047, 12'd1440);
    send_pixel(16'd1, 12'd2048, 12'd1441);
    send_pixel(16'hFFFF, 12'd2047, 12'd1440);
    send_pixel(16'hFFFF, 12'd2048, 12'd1441);
    send_pixel(16'd0, 12'd2047, 12'd1440);
    // zero reciprocal on y
    configure(16'h1234, 16'h0FFF, 32'h8000_0000, 32'h0000_0000);
    send_pixel(16'h8000, 12'd0, 12'd0);
    send_pixel(16'h8000, 12'hFFF, 12'hFFF);
    send_pixel(16'd3, 12'h123, 12'h0FF);
  endtask

  task automatic test_random_traffic(int blocks, int per_block);
    for (int b = 0; b < blocks; b++) begin
      configure(CenterW'(pick_value(CenterW)), CenterW'(pick_value(CenterW)),
                pick_value(InvW), pick_value(InvW));
      for (int i = 0; i < per_block; i++) send_pixel(pick_depth(), pick_pix(), pick_pix());
    end
  endtask

  // receiver holds off while pixels keep coming, so the pipeline fills and stalls
  task automatic test_stall_fill();
    configure(CenterW'(pick_value(CenterW)), CenterW'(pick_value(CenterW)),
              pick_value(InvW), pick_value(InvW));
    for (int i = 0; i < 8; i++) send_pixel(DepthW'($urandom_range(65535, 1)),
                                           pick_pix(), pick_pix());
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_pixel(DepthW'($urandom_range(65535, 1)),
                                            pick_pix(), pick_pix());
  endtask

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pt.ready <= 1'b0;
    end else begin
      pt.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pt.valid && pt.ready) begin
      if (points_due.size() == 0) begin
        $error("point with no pixel pending: col %0d row %0d", pt.source_col,
               pt.source_row);
        mismatches++;
      end else begin
        due_pt = points_due.pop_front();
        if (pt.point_x !== due_pt.x) begin
          $error("point_x expected %0d got %0d", due_pt.x, pt.point_x);
          mismatches++;
        end
        if (pt.point_y !== due_pt.y) begin
          $error("point_y expected %0d got %0d", due_pt.y, pt.point_y);
          mismatches++;
        end
        if (pt.point_z !== due_pt.z) begin
          $error("point_z expected %0d got %0d", due_pt.z, pt.point_z);
          mismatches++;
        end
        if (pt.source_col !== due_pt.col) begin
          $error("source_col expected %0d got %0d", due_pt.col, pt.source_col);
          mismatches++;
        end
        if (pt.source_row !== due_pt.row) begin
          $error("source_row expected %0d got %0d", due_pt.row, pt.source_row);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || psel_i || (pix.valid && pix.ready) || (pt.valid && pt.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("depth_pixel_back_projection_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel_i = 1'b0;
    penable_i = 1'b0;
    pwrite_i = 1'b0;
    paddr_i = '0;
    pwdata_i = '0;
    pix.valid = 1'b0;
    pix.depth = '0;
    pix.pixel_col = '0;
    pix.pixel_row = '0;
    pt.ready = 1'b0;
    cam_cx = '0;
    cam_cy = '0;
    cam_inv_fx = '0;
    cam_inv_fy = '0;
    mismatches = 0;
    stall_cycles = 0;
    hold_left = 0;
    hold_req = 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 79;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_corners();
    test_random_traffic(3, 120);
    send_idle_pct = 79;
    recv_idle_pct = 23;
    test_random_traffic(3, 120);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(3, 120);
    test_stall_fill();

    settle();
    if (mismatches == 0) begin
      $display("depth_pixel_back_projection_unit_tb OK");
    end else begin
      $display("depth_pixel_back_projection_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
